// ----- rtl/core/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, constants and helpers of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_STOP   = 8;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COPY_END   = (ROWS - 1) * COLUMNS;

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 16;

  // Cursor values before wrap handling need one extra bit.
  localparam int unsigned COLX_W = COL_W + 1;
  localparam int unsigned ROWX_W = ROW_W + 1;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // Operation codes.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // Character codes.
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_BLANK};

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] read_cell;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
  } color_t;

  // Linear cell address of a row and column inside the screen.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

endpackage

// ----- rtl/core/tccw_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Cell store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram import tccw_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer of the console: cursor update, cell writes, and the sweeps that
// clear or scroll the cell store through one shared address counter.
// ----------------------------------------------------------------------------
module tccw_ctrl import tccw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  color_t  color_i,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  item_t             item_q, item_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              scrolled_q, scrolled_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] idx_inc;
  logic [ADDR_W-1:0] idx_dec;
  logic [CELL_W-1:0] blank;
  logic              printable;
  logic              read_in_range;
  logic [COLX_W-1:0] col_x;
  logic [ROWX_W-1:0] row_x;
  logic              put_scroll;

  tccw_cell_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx_inc = idx_q + ADDR_W'(1);
  assign idx_dec = idx_q - ADDR_W'(1);
  assign blank   = {color_i, CH_BLANK};

  assign printable = (item_q.char_code != CH_NEWLINE) && (item_q.char_code != CH_RETURN) &&
                     (item_q.char_code != CH_TAB) && (item_q.char_code != CH_BACKSPACE);

  assign read_in_range = (ROWX_W'(item_q.read_row) < ROWX_W'(ROWS)) &&
                         (COLX_W'(item_q.read_col) < COLX_W'(COLUMNS));

  // Cursor step for a put, followed by column wrap and row overflow.
  always_comb begin
    col_x      = COLX_W'(col_q);
    row_x      = ROWX_W'(row_q);
    put_scroll = 1'b0;
    priority if (item_q.char_code == CH_NEWLINE) begin
      col_x = '0;
      row_x = row_x + ROWX_W'(1);
    end else if (item_q.char_code == CH_RETURN) begin
      col_x = '0;
    end else if (item_q.char_code == CH_TAB) begin
      col_x = col_x - (col_x % COLX_W'(TAB_STOP)) + COLX_W'(TAB_STOP);
    end else if (item_q.char_code == CH_BACKSPACE) begin
      if (col_x != '0) begin
        col_x = col_x - COLX_W'(1);
      end
    end else begin
      col_x = col_x + COLX_W'(1);
    end
    if (col_x >= COLX_W'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + ROWX_W'(1);
    end
    if (row_x >= ROWX_W'(ROWS)) begin
      row_x      = ROWX_W'(ROWS - 1);
      put_scroll = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    cell_q     <= cell_d;
    scrolled_q <= scrolled_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    item_d       = item_q;
    col_d        = col_q;
    row_d        = row_q;
    cell_d       = cell_q;
    scrolled_d   = scrolled_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = blank;
    ram_re       = 1'b0;
    ram_raddr    = idx_q + ADDR_W'(COLUMNS);
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // Power-up pass over the store with the reset blank.
        ram_we    = 1'b1;
        ram_wdata = RESET_BLANK;
        if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scrolled_d = 1'b0;
        cell_d     = '0;
        unique case (item_q.operation)
          OP_PUT: begin
            if (printable) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(row_q, col_q);
              ram_wdata = {color_i, item_q.char_code};
            end
            col_d = COL_W'(col_x);
            row_d = ROW_W'(row_x);
            if (put_scroll) begin
              scrolled_d = 1'b1;
              idx_d      = '0;
              state_d    = ST_COPY;
            end else begin
              state_d = ST_DONE;
            end
          end
          OP_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            idx_d   = '0;
            state_d = ST_BLANK;
          end
          OP_READ: begin
            if (read_in_range) begin
              ram_re    = 1'b1;
              ram_raddr = cell_addr(item_q.read_row, item_q.read_col);
              state_d   = ST_RDWAIT;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_RDWAIT: begin
        cell_d  = ram_rdata;
        state_d = ST_DONE;
      end
      ST_COPY: begin
        // The read one row below is issued here and its data is written in the next cycle.
        if (idx_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec;
          ram_wdata = ram_rdata;
        end
        if (idx_q == ADDR_W'(COPY_END)) begin
          state_d = ST_BLANK;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_inc;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.cursor_col = col_q;
  assign res_o.cursor_row = row_q;
  assign res_o.read_cell  = cell_q;
  assign res_o.scrolled   = scrolled_q;

endmodule

// ----- rtl/core/text_console_cell_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text-mode console with an 80x25 cell store, cursor handling and scrolling.
//
// Channel  | Direction | Contents
// ---------+-----------+-----------------------------------------------------
// s_*      | in        | tuser: operation; tdata: char_code, read_row, read_col
// m_*      | out       | tdata: cursor_col, cursor_row, read_cell, scrolled
// cfg_*    | in        | register writes: 0 fg_color, 1 bg_color
//
// An on-screen read passes through a wait state for the registered cell data.
// A put that scrolls walks the store through the single cell memory port pair,
// moving each row one row up and then blanking the last row. A clear blanks
// the whole store. After reset, a clearing pass over all CELL_COUNT cells runs
// before the first input transfer. The result waits in an output register, so
// a stalled output holds one finished item while the next one is taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top import tccw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // [1:0] operation
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // [6:0] cursor_col, [11:7] cursor_row, [27:12] read_cell, [28] scrolled,
  // [31:29] zero
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  color_t                  color_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;
  item_t                   item;
  result_t                 res;
  logic                    res_valid;
  logic                    res_ready;

  assign item.operation = s_tuser_i;
  assign item.char_code = s_tdata_i[7:0];
  assign item.read_row  = s_tdata_i[12:8];
  assign item.read_col  = s_tdata_i[19:13];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q.fg <= FG_RESET;
      color_q.bg <= BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FG_COLOR: color_q.fg <= cfg_wdata_i;
        REG_BG_COLOR: color_q.bg <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tccw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_i      (color_q),
    .item_valid_i (s_tvalid_i),
    .item_ready_o (s_tready_o),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= OUT_DATA_W'({res.scrolled, res.read_cell, res.cursor_row, res.cursor_col});
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule
